/* sv/rpaf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rpaf_pkg;

  localparam int CHANNELS_DEF      = 32;
  localparam int HISTORY_DEPTH_DEF = 64;

  // The history ring is split into this many banks; one row of all banks is
  // compared per cycle. Must be a power of two, at least two.
  localparam int HIST_BANKS  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int REL_W     = 3;
  localparam int IDX_W     = 28;
  localparam int CH_FIELD_W = 8;
  localparam int VERDICT_W = 3;

  typedef logic [REL_W-1:0]      rel_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CH_FIELD_W-1:0] chan_t;
  typedef logic [VERDICT_W-1:0]  verdict_t;

  // Reliability codes carried in the packet header.
  localparam rel_t REL_UNRELIABLE          = 3'd0;
  localparam rel_t REL_UNRELIABLE_SEQ      = 3'd1;
  localparam rel_t REL_RELIABLE            = 3'd2;
  localparam rel_t REL_RELIABLE_ORD        = 3'd3;
  localparam rel_t REL_RELIABLE_SEQ        = 3'd4;
  localparam rel_t REL_UNRELIABLE_ACK      = 3'd5;
  localparam rel_t REL_RELIABLE_ACK        = 3'd6;
  localparam rel_t REL_RELIABLE_ORD_ACK    = 3'd7;

  localparam verdict_t V_DELIVER       = 3'd0;
  localparam verdict_t V_DUPLICATE     = 3'd1;
  localparam verdict_t V_BAD_CHANNEL   = 3'd2;
  localparam verdict_t V_OLD_SEQUENCED = 3'd3;
  localparam verdict_t V_HELD_AHEAD    = 3'd4;
  localparam verdict_t V_OLD_ORDERED   = 3'd5;

  // What the back end still has to do with an item.
  typedef enum logic [2:0] {
    KIND_PASS = 3'd0,
    KIND_DUP  = 3'd1,
    KIND_BAD  = 3'd2,
    KIND_SEQ  = 3'd3,
    KIND_ORD  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t kind;
    idx_t  idx;
    chan_t ch;
  } token_t;

  function automatic logic rpaf_is_reliable(rel_t r);
    logic res;
    case (r) inside
      REL_RELIABLE, REL_RELIABLE_ORD, REL_RELIABLE_SEQ,
      REL_RELIABLE_ACK, REL_RELIABLE_ORD_ACK: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic logic rpaf_is_sequenced(rel_t r);
    logic res;
    case (r) inside
      REL_UNRELIABLE_SEQ, REL_RELIABLE_SEQ: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic logic rpaf_is_ordered(rel_t r);
    logic res;
    case (r) inside
      REL_RELIABLE_ORD, REL_RELIABLE_ORD_ACK: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/rpaf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpaf_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/rpaf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpaf_front #(
  parameter int CHANNELS      = rpaf_pkg::CHANNELS_DEF,
  parameter int HISTORY_DEPTH = rpaf_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire rpaf_pkg::rel_t   in_reliability,
  input  wire rpaf_pkg::idx_t   in_message_index,
  input  wire rpaf_pkg::idx_t   in_sequenced_index,
  input  wire rpaf_pkg::idx_t   in_ordered_index,
  input  wire rpaf_pkg::chan_t  in_order_channel,
  output logic                  tok_push,
  output rpaf_pkg::token_t      tok,
  input  wire logic             q_full
);

  import rpaf_pkg::*;

  localparam int ROWS   = (HISTORY_DEPTH + HIST_BANKS - 1) / HIST_BANKS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BANK_W = $clog2(HIST_BANKS);
  localparam int EIDX_W = ROW_W + BANK_W;
  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W  = (EIDX_W > FILL_W) ? EIDX_W : FILL_W;

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_SCAN  = 4'b0010,
    F_DRAIN = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;

  rel_t  rel_r;
  idx_t  midx_r, sidx_r, oidx_r;
  chan_t ch_r;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ROW_W-1:0]  cmp_row_r, cmp_row_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              hit_r, hit_nxt;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic                  accept;
  logic                  hist_we;
  logic                  reliable, sequenced, ordered, bad_ch;
  logic [EIDX_W-1:0]     wptr_ext;
  logic [BANK_W-1:0]     wbank;
  logic [ROW_W-1:0]      wrow;
  idx_t                  rdata [HIST_BANKS];
  logic [HIST_BANKS-1:0] bank_match;

  assign full   = (state_r != F_IDLE);
  assign accept = push && !full;

  assign reliable  = rpaf_is_reliable(rel_r);
  assign sequenced = rpaf_is_sequenced(rel_r);
  assign ordered   = rpaf_is_ordered(rel_r);
  assign bad_ch    = ({1'b0, ch_r} >= (CH_FIELD_W + 1)'(CHANNELS));

  // Entry i of the ring lives in bank i mod HIST_BANKS, row i / HIST_BANKS.
  assign wptr_ext = EIDX_W'(wptr_r);
  assign wbank    = wptr_ext[BANK_W-1:0];
  assign wrow     = wptr_ext[EIDX_W-1:BANK_W];

  assign tok_push = (state_r == F_PUSH) && !q_full;
  assign hist_we  = tok_push && reliable && !hit_r;

  for (genvar b = 0; b < HIST_BANKS; b++) begin : g_bank
    rpaf_ram #(
      .WIDTH (IDX_W),
      .DEPTH (ROWS)
    ) u_bank (
      .clk   (clk),
      .we    (hist_we && (wbank == BANK_W'(b))),
      .waddr (wrow),
      .wdata (midx_r),
      .raddr (row_r),
      .rdata (rdata[b])
    );

    // Entries at or beyond the fill count have never been written.
    assign bank_match[b] = cmp_vld_r && (rdata[b] == midx_r) &&
                           (CMP_W'({cmp_row_r, BANK_W'(b)}) < CMP_W'(fill_r));
  end

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    hit_nxt     = hit_r || (|bank_match);
    cmp_vld_nxt = (state_r == F_SCAN);
    cmp_row_nxt = row_r;
    wptr_nxt    = wptr_r;
    fill_nxt    = fill_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          row_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = rpaf_is_reliable(in_reliability) ? F_SCAN : F_PUSH;
        end
      end
      F_SCAN: begin
        row_nxt = row_r + 1'b1;
        if (row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = F_DRAIN;
        end
      end
      F_DRAIN: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
        if (hist_we) begin
          wptr_nxt = (wptr_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
          if (fill_r != FILL_W'(HISTORY_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Classification of the finished item for the back end.
  always_comb begin
    tok.ch  = ch_r;
    tok.idx = sequenced ? sidx_r : oidx_r;
    if (reliable && hit_r) begin
      tok.kind = KIND_DUP;
    end else if (!sequenced && !ordered) begin
      tok.kind = KIND_PASS;
    end else if (bad_ch) begin
      tok.kind = KIND_BAD;
    end else if (sequenced) begin
      tok.kind = KIND_SEQ;
    end else begin
      tok.kind = KIND_ORD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      row_r     <= '0;
      cmp_row_r <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      wptr_r    <= '0;
      fill_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      cmp_row_r <= cmp_row_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      hit_r     <= hit_nxt;
      wptr_r    <= wptr_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rel_r  <= in_reliability;
      midx_r <= in_message_index;
      sidx_r <= in_sequenced_index;
      oidx_r <= in_ordered_index;
      ch_r   <= in_order_channel;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill count above depth");

  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FILL_W'(HISTORY_DEPTH)) |-> (FILL_W'(wptr_r) == fill_r))
    else $error("write pointer out of step with fill count before wrap");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> full)
    else $error("front end free again right after taking an item");

endmodule

`default_nettype wire

/* sv/rpaf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpaf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rpaf_pkg::token_t  push_tok,
  output logic                   full,
  input  wire logic              pop,
  output rpaf_pkg::token_t       head,
  output logic                   empty
);

  import rpaf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

/* sv/rpaf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpaf_back #(
  parameter int CHANNELS = rpaf_pkg::CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire rpaf_pkg::token_t   tok,
  input  wire logic               pop,
  output logic                    empty,
  output rpaf_pkg::verdict_t      out_verdict
);

  import rpaf_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } bstate_t;

  bstate_t state_r, state_nxt;

  kind_t          kind_r;
  idx_t           idx_r;
  logic [CH_W-1:0] ch_r;

  logic [CHANNELS-1:0] seq_vld_r, seq_vld_nxt;
  logic [CHANNELS-1:0] ord_vld_r, ord_vld_nxt;
  logic                out_vld_r, out_vld_nxt;
  verdict_t            verdict_r, verdict_nxt;

  logic [CH_W-1:0] raddr;
  idx_t            rdata_s, rdata_o;
  idx_t            exp_s, exp_o;
  idx_t            next_idx;
  logic            slot_free, load;
  logic            seq_adv, ord_adv;
  logic            seq_we, ord_we;
  verdict_t        verdict_calc;

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  // The channel stores are read with the queue head while idle and then
  // held on the latched channel until the result is loaded.
  assign raddr = (state_r == B_IDLE) ? tok.ch[CH_W-1:0] : ch_r;

  rpaf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CHANNELS)
  ) u_exp_seq (
    .clk   (clk),
    .we    (seq_we),
    .waddr (ch_r),
    .wdata (next_idx),
    .raddr (raddr),
    .rdata (rdata_s)
  );

  rpaf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CHANNELS)
  ) u_exp_ord (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ch_r),
    .wdata (next_idx),
    .raddr (raddr),
    .rdata (rdata_o)
  );

  // A channel that was never advanced still expects index zero.
  assign exp_s    = seq_vld_r[ch_r] ? rdata_s : '0;
  assign exp_o    = ord_vld_r[ch_r] ? rdata_o : '0;
  assign next_idx = idx_r + 1'b1;

  assign slot_free = !out_vld_r || pop;
  assign load      = (state_r == B_EXEC) && slot_free;
  assign seq_we    = load && seq_adv;
  assign ord_we    = load && ord_adv;
  assign empty     = !out_vld_r;
  assign out_verdict = verdict_r;

  always_comb begin
    seq_adv      = 1'b0;
    ord_adv      = 1'b0;
    verdict_calc = V_DELIVER;
    unique case (kind_r)
      KIND_PASS: verdict_calc = V_DELIVER;
      KIND_DUP:  verdict_calc = V_DUPLICATE;
      KIND_BAD:  verdict_calc = V_BAD_CHANNEL;
      KIND_SEQ: begin
        if (idx_r < exp_s) begin
          verdict_calc = V_OLD_SEQUENCED;
        end else begin
          seq_adv = 1'b1;
        end
      end
      KIND_ORD: begin
        if (idx_r == exp_o) begin
          ord_adv = 1'b1;
        end else if (idx_r > exp_o) begin
          verdict_calc = V_HELD_AHEAD;
        end else begin
          verdict_calc = V_OLD_ORDERED;
        end
      end
      default: verdict_calc = V_DELIVER;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    seq_vld_nxt = seq_vld_r;
    ord_vld_nxt = ord_vld_r;
    out_vld_nxt = out_vld_r;
    verdict_nxt = verdict_r;
    if (pop) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (load) begin
          state_nxt   = B_IDLE;
          out_vld_nxt = 1'b1;
          verdict_nxt = verdict_calc;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    if (seq_we) begin
      seq_vld_nxt[ch_r] = 1'b1;
    end
    if (ord_we) begin
      ord_vld_nxt[ch_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      seq_vld_r <= '0;
      ord_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seq_vld_r <= seq_vld_nxt;
      ord_vld_r <= ord_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    if (q_pop) begin
      kind_r <= tok.kind;
      idx_r  <= tok.idx;
      ch_r   <= tok.ch[CH_W-1:0];
    end
  end

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EXEC && !slot_free) |=> (state_r == B_EXEC))
    else $error("item left the execute stage without a free result slot");

  a_seq_marked: assert property (@(posedge clk) disable iff (!rst_n)
    seq_we |=> seq_vld_r[$past(ch_r)])
    else $error("sequenced channel advanced but not marked written");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !empty)
    else $error("verdict loaded but result side still empty");

endmodule

`default_nettype wire

/* sv/reliable_packet_admission_filter_core.sv */
// A reliable item is swept through every row of the banked history and then handed to the queue;
// any other item goes to the queue directly. The back end pops it, reads the channel stores and
// loads the verdict, waiting while the result side still holds the last one. The history scan
// paces reliable items; the front end takes a new item while the back end works on the last.
// Reset (synchronous, active low) clears all control state, the history fill count and the
// per-channel written bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module reliable_packet_admission_filter_core #(
  parameter int CHANNELS      = rpaf_pkg::CHANNELS_DEF,
  parameter int HISTORY_DEPTH = rpaf_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input item channel, queue style.
  input  wire logic              push,
  output logic                   full,
  input  wire rpaf_pkg::rel_t    in_reliability,
  input  wire rpaf_pkg::idx_t    in_message_index,
  input  wire rpaf_pkg::idx_t    in_sequenced_index,
  input  wire rpaf_pkg::idx_t    in_ordered_index,
  input  wire rpaf_pkg::chan_t   in_order_channel,
  // Result item channel, queue style.
  output logic                   empty,
  input  wire logic              pop,
  output rpaf_pkg::verdict_t     out_verdict
);

  import rpaf_pkg::*;

  // The front end takes one item at a time. For a reliable item it sweeps
  // the duplicate history, one row of all banks per cycle, and then records
  // the message index if it was not seen. It also settles whether the item
  // is a duplicate, needs no channel work, or has a channel out of range,
  // and hands a compact item to the queue.
  //
  // The back end pops the queue, reads the per-channel expected indices,
  // applies the sequenced or ordered rule, and loads the verdict into the
  // output register. A waiting verdict does not stop the front end: the
  // queue in between absorbs up to two items while the result side stalls.

  logic   tok_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  token_t front_tok;
  token_t head_tok;

  rpaf_front #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_reliability     (in_reliability),
    .in_message_index   (in_message_index),
    .in_sequenced_index (in_sequenced_index),
    .in_ordered_index   (in_ordered_index),
    .in_order_channel   (in_order_channel),
    .tok_push           (tok_push),
    .tok                (front_tok),
    .q_full             (q_full)
  );

  // Short item queue between classification and channel execution.
  rpaf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_push),
    .push_tok (front_tok),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_tok),
    .empty    (q_empty)
  );

  rpaf_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .tok         (head_tok),
    .pop         (pop),
    .empty       (empty),
    .out_verdict (out_verdict)
  );

endmodule

`default_nettype wire

/* dv/reliable_packet_admission_filter_core_tb.sv */
`timescale 1ns / 1ps

module reliable_packet_admission_filter_core_tb;

  import rpaf_pkg::*;

  localparam int NUM_CHANNELS = CHANNELS_DEF;
  localparam int HIST_SLOTS   = HISTORY_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1750;

  // Header fields of one packet, as they sit on the input ports.
  typedef struct {
    rel_t  rel;
    idx_t  msg;
    idx_t  seq;
    idx_t  ord;
    chan_t ch;
  } header_t;

  // Tracks the duplicate history and the per-channel sequence state, and
  // keeps the verdicts that the block still owes, oldest first.
  class admission_scoreboard;
    idx_t        seen_idx[HIST_SLOTS];
    bit          seen_valid[HIST_SLOTS];
    int unsigned seen_wr;
    idx_t        next_seq[NUM_CHANNELS];
    idx_t        next_ord[NUM_CHANNELS];
    verdict_t    verdicts_due[$];
    int unsigned mismatches;

    function new();
      foreach (seen_valid[i]) seen_valid[i] = 1'b0;
      foreach (next_seq[i]) begin
        next_seq[i] = '0;
        next_ord[i] = '0;
      end
      seen_wr    = 0;
      mismatches = 0;
    endfunction

    function verdict_t judge(header_t h);
      bit reliable;
      bit sequenced;
      bit ordered;
      reliable  = h.rel inside {REL_RELIABLE, REL_RELIABLE_ORD, REL_RELIABLE_SEQ,
                                REL_RELIABLE_ACK, REL_RELIABLE_ORD_ACK};
      sequenced = h.rel inside {REL_UNRELIABLE_SEQ, REL_RELIABLE_SEQ};
      ordered   = h.rel inside {REL_RELIABLE_ORD, REL_RELIABLE_ORD_ACK};
      if (reliable) begin
        foreach (seen_idx[i])
          if (seen_valid[i] && seen_idx[i] == h.msg) return V_DUPLICATE;
        // A fresh index is recorded even if the channel rules reject the packet.
        seen_idx[seen_wr]   = h.msg;
        seen_valid[seen_wr] = 1'b1;
        seen_wr             = (seen_wr + 1) % HIST_SLOTS;
      end
      if (!sequenced && !ordered) return V_DELIVER;
      if (h.ch >= NUM_CHANNELS) return V_BAD_CHANNEL;
      if (sequenced) begin
        if (h.seq < next_seq[h.ch]) return V_OLD_SEQUENCED;
        next_seq[h.ch] = h.seq + 1'b1;
        return V_DELIVER;
      end
      if (h.ord == next_ord[h.ch]) begin
        next_ord[h.ch] = h.ord + 1'b1;
        return V_DELIVER;
      end
      return (h.ord > next_ord[h.ch]) ? V_HELD_AHEAD : V_OLD_ORDERED;
    endfunction

    function void note_item(header_t h);
      verdict_t v;
      v = judge(h);
      verdicts_due.insert(verdicts_due.size(), v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("out_verdict: no item outstanding, actual %0d", got);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $error("out_verdict: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return verdicts_due.size();
    endfunction
  endclass

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     push  = 1'b0;
  logic     pop   = 1'b0;
  rel_t     in_reliability     = '0;
  idx_t     in_message_index   = '0;
  idx_t     in_sequenced_index = '0;
  idx_t     in_ordered_index   = '0;
  chan_t    in_order_channel   = '0;
  logic     full;
  logic     empty;
  verdict_t out_verdict;

  admission_scoreboard sb = new();

  // Message indices sent lately. Reusing them produces duplicates while they
  // are still in the history ring and fresh admissions once they have aged out.
  idx_t sent_msgs[$];

  reliable_packet_admission_filter_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_reliability     (in_reliability),
    .in_message_index   (in_message_index),
    .in_sequenced_index (in_sequenced_index),
    .in_ordered_index   (in_ordered_index),
    .in_order_channel   (in_order_channel),
    .empty              (empty),
    .pop                (pop),
    .out_verdict        (out_verdict)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle stretches: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic header_t mk(rel_t rel, idx_t msg, idx_t seq, idx_t ord, chan_t ch);
    header_t h;
    h.rel = rel;
    h.msg = msg;
    h.seq = seq;
    h.ord = ord;
    h.ch  = ch;
    return h;
  endfunction

  // An index close to what the channel expects next, so that most packets
  // land on the interesting side of the comparisons. Some go near the top of
  // the index range to make the sequenced expectation wrap around.
  function automatic idx_t around(idx_t base);
    int unsigned pick = $urandom_range(0, 99);
    if (pick < 55) return base;
    if (pick < 72) return base + idx_t'($urandom_range(1, 4));
    if (pick < 88) return base - idx_t'($urandom_range(1, 4));
    if (pick < 94) return idx_t'($urandom);
    return idx_t'('1) - idx_t'($urandom_range(0, 2));
  endfunction

  // Builds a random header from the tracked state. Every field is always
  // randomized first so that unused fields still toggle all their bits.
  function automatic header_t random_header();
    header_t     h;
    int unsigned pick;
    h.rel = rel_t'($urandom_range(0, 7));
    h.msg = idx_t'($urandom);
    h.seq = idx_t'($urandom);
    h.ord = idx_t'($urandom);
    h.ch  = chan_t'($urandom_range(0, NUM_CHANNELS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 30 && sent_msgs.size() > 0)
      h.msg = sent_msgs[$urandom_range(0, sent_msgs.size() - 1)];
    else if (pick < 33)
      h.msg = '0;
    else if (pick < 36)
      h.msg = '1;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      h.ch = chan_t'($urandom_range(NUM_CHANNELS, 255));
    else if (pick < 11)
      h.ch = chan_t'($urandom);
    if (h.ch < NUM_CHANNELS) begin
      h.seq = around(sb.next_seq[h.ch]);
      h.ord = around(sb.next_ord[h.ch]);
    end
    return h;
  endfunction

  // Offers one item and waits for the block to take it. The push strobe is
  // left high when no gap follows, so back-to-back items never toggle it.
  task automatic send_item(header_t h, bit may_idle);
    int unsigned gap;
    in_reliability     <= h.rel;
    in_message_index   <= h.msg;
    in_sequenced_index <= h.seq;
    in_ordered_index   <= h.ord;
    in_order_channel   <= h.ch;
    push               <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_item(h);
    sent_msgs.insert(sent_msgs.size(), h.msg);
    if (sent_msgs.size() > 128) void'(sent_msgs.pop_front());
    gap = may_idle ? idle_len() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items until every outstanding verdict has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Result side. Verdicts are sampled at the edge where pop meets a non-empty
  // queue. The sink stalls at random, except in a window at the start of each
  // period of its cycle count, and twice holds off for a long stretch so that
  // the block fills up and pushes back on the sender.
  initial begin : result_sink
    int unsigned hold;
    int unsigned popped;
    int unsigned cyc;
    hold   = 0;
    popped = 0;
    cyc    = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) continue;
      cyc++;
      if (pop && !empty) begin
        sb.check_verdict(out_verdict);
        popped++;
        if (popped == 30 || popped == 1000) hold = 300;
      end
      if (hold == 0 && (cyc % 1000) >= 150 && $urandom_range(0, 3) == 0)
        hold = idle_len();
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus: reset, a directed part that walks the special cases, a full
  // drain, then the random part with one more drain in the middle and one at the end.
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Packets without channel rules are delivered whatever the channel says.
    send_item(mk(REL_UNRELIABLE, '0, '0, '0, '0), 1'b1);
    send_item(mk(REL_UNRELIABLE, '1, '1, '1, '1), 1'b1);
    // A reliable index is admitted once, then seen as a duplicate.
    send_item(mk(REL_RELIABLE, '0, '0, '0, 8'd3), 1'b1);
    send_item(mk(REL_RELIABLE, '0, '1, '1, 8'd3), 1'b1);
    send_item(mk(REL_RELIABLE_ACK, '1, '0, '0, '0), 1'b1);
    // The unreliable acknowledged variant never consults the history.
    send_item(mk(REL_UNRELIABLE_ACK, '1, '0, '0, '0), 1'b1);
    // A bad channel still leaves the index recorded, so the resend is a duplicate.
    send_item(mk(REL_RELIABLE_ORD, 28'd1, '0, '0, 8'd255), 1'b1);
    send_item(mk(REL_RELIABLE_ORD, 28'd1, '0, '0, 8'd0), 1'b1);
    // Channel bound: the first channel out of range, then the last one in range.
    send_item(mk(REL_UNRELIABLE_SEQ, '0, 28'd7, '0, chan_t'(NUM_CHANNELS)), 1'b1);
    send_item(mk(REL_UNRELIABLE_SEQ, '0, 28'hFFFFFFE, '0, chan_t'(NUM_CHANNELS - 1)), 1'b1);
    send_item(mk(REL_UNRELIABLE_SEQ, '0, 28'd5, '0, chan_t'(NUM_CHANNELS - 1)), 1'b1);
    // Sequenced expectation wraps from the top index back to zero.
    send_item(mk(REL_RELIABLE_SEQ, 28'd2, '1, '0, chan_t'(NUM_CHANNELS - 1)), 1'b1);
    send_item(mk(REL_UNRELIABLE_SEQ, '0, '0, '0, chan_t'(NUM_CHANNELS - 1)), 1'b1);
    // Ordered channel: in order, ahead, behind, in order again, far ahead.
    send_item(mk(REL_RELIABLE_ORD, 28'd3, '0, 28'd0, 8'd0), 1'b1);
    send_item(mk(REL_RELIABLE_ORD_ACK, 28'd4, '0, 28'd5, 8'd0), 1'b1);
    send_item(mk(REL_RELIABLE_ORD_ACK, 28'd5, '0, 28'd0, 8'd0), 1'b1);
    send_item(mk(REL_RELIABLE_ORD, 28'd6, '0, 28'd1, 8'd0), 1'b1);
    send_item(mk(REL_RELIABLE_ORD, 28'd7, '0, '1, 8'd0), 1'b1);
    // Sequenced packet equal to the expected index is not old.
    send_item(mk(REL_RELIABLE_SEQ, 28'd8, 28'd1, '0, chan_t'(NUM_CHANNELS - 1)), 1'b1);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      // The first items of every block of two hundred go out back to back.
      send_item(random_header(), (n % 200) >= 40);
    end
    drain_results();
    repeat (24) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a correct run takes a small fraction of this.
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
sv/rpaf_pkg.sv
sv/rpaf_ram.sv
sv/rpaf_front.sv
sv/rpaf_queue.sv
sv/rpaf_back.sv
sv/reliable_packet_admission_filter_core.sv
dv/reliable_packet_admission_filter_core_tb.sv
